### rtl/pth_pkg.sv
// Shared types and constants for the sensor compensation core.
// Holds the input/result word layouts, the calibration set and register map.
// No dependencies.
package pth_pkg;

    localparam int ADDR_W  = 6;
    localparam int DATA_W  = 64;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] REG_TEMP_CAL       = 3'd0;
    localparam logic [2:0] REG_PRESS_CAL_LO   = 3'd1;
    localparam logic [2:0] REG_PRESS_CAL_HI   = 3'd2;
    localparam logic [2:0] REG_PRESS_CAL_NINE = 3'd3;
    localparam logic [2:0] REG_HUM_CAL_A      = 3'd4;
    localparam logic [2:0] REG_HUM_CAL_B      = 3'd5;

    typedef struct packed {
        logic [19:0] raw_pressure;
        logic [19:0] raw_temperature;
        logic [15:0] raw_humidity;
    } in_word_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
    } out_word_t;

    typedef struct packed {
        logic [47:0] temp_cal;
        logic [63:0] press_cal_lo;
        logic [63:0] press_cal_hi;
        logic [15:0] press_cal_nine;
        logic [31:0] hum_cal_a;
        logic [31:0] hum_cal_b;
    } cal_t;

endpackage

### rtl/pth_front.sv
// Input side: accepts raw measurement words into a two-entry queue.
// Depends on pth_pkg.
module pth_front import pth_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_data,
    output logic     q_valid,
    input  logic     q_pop,
    output in_word_t q_data
);
    in_word_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 push;
    logic                 pop;

    assign s_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### rtl/pth_mul.sv
// 64-bit wrapping multiplier built from one 32x32 multiplier, reused in phases.
// Depends on pth_pkg.
module pth_mul import pth_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] p
);
    logic              busy_reg;
    logic [1:0]        ph_reg;
    logic              done_reg;
    logic [63:0]       a_reg;
    logic [63:0]       b_reg;
    logic [63:0]       m_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       p_reg;
    logic [31:0]       ma;
    logic [31:0]       mb;

    assign ma   = (ph_reg == 2'd2) ? a_reg[63:32] : a_reg[31:0];
    assign mb   = (ph_reg == 2'd1) ? b_reg[63:32] : b_reg[31:0];
    assign done = done_reg;
    assign p    = p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= '0;
            end else if (busy_reg) begin
                ph_reg <= ph_reg + 1'b1;
                if (ph_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
        end
        m_reg <= 64'(ma) * 64'(mb);
        case (ph_reg)
            2'd1:    acc_reg <= m_reg;
            2'd2:    acc_reg <= acc_reg + {m_reg[31:0], 32'd0};
            2'd3:    p_reg   <= acc_reg + {m_reg[31:0], 32'd0};
            default: acc_reg <= acc_reg;
        endcase
    end

`ifndef SYNTHESIS
    a_mul_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> ##4 done_reg)
        else $error("multiply did not finish in time");
`endif

endmodule

### rtl/pth_div.sv
// Signed 64-bit divider, truncating toward zero, one quotient bit per cycle.
// Depends on pth_pkg.
module pth_div import pth_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              done,
    output logic [DATA_W-1:0] q
);
    logic        busy_reg;
    logic        fix_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg;
    logic [63:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] ub_reg;
    logic [63:0] q_reg;
    logic [64:0] trial;

    assign trial = {rem_reg, quo_reg[63]} - {1'b0, ub_reg};
    assign done  = done_reg;
    assign q     = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fix_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
            end else if (fix_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= a[63] ^ b[63];
            quo_reg <= a[63] ? 64'd0 - a : a;
            ub_reg  <= b[63] ? 64'd0 - b : b;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_reg <= trial[63:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[62:0], quo_reg[63]};
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
        if (fix_reg) begin
            q_reg <= neg_reg ? 64'd0 - quo_reg : quo_reg;
        end
    end

`ifndef SYNTHESIS
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(fix_reg))
        else $error("divide finished without sign fix");
`endif

endmodule

### rtl/pth_back.sv
// Compensation sequencer: runs the temperature, pressure and humidity equations
// on the shared multiplier and divider, and holds the result word register.
// Depends on pth_pkg, pth_mul, pth_div.
module pth_back import pth_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cal_t      cal,
    input  logic      q_valid,
    input  in_word_t  q_data,
    output logic      q_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ISSUE     = 3'd1;
    localparam logic [2:0] ST_WAIT      = 3'd2;
    localparam logic [2:0] ST_DIV_ISSUE = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd4;
    localparam logic [2:0] ST_FIN       = 3'd5;
    localparam logic [2:0] ST_EMIT      = 3'd6;

    localparam logic [4:0] S_T_LIN  = 5'd0;
    localparam logic [4:0] S_T_SQ   = 5'd1;
    localparam logic [4:0] S_T_CUBE = 5'd2;
    localparam logic [4:0] S_T_OUT  = 5'd3;
    localparam logic [4:0] S_P_SQ   = 5'd4;
    localparam logic [4:0] S_P_V2A  = 5'd5;
    localparam logic [4:0] S_P_V2B  = 5'd6;
    localparam logic [4:0] S_P_V1A  = 5'd7;
    localparam logic [4:0] S_P_V1B  = 5'd8;
    localparam logic [4:0] S_P_V1C  = 5'd9;
    localparam logic [4:0] S_P_NUM  = 5'd10;
    localparam logic [4:0] S_P_Q9   = 5'd12;
    localparam logic [4:0] S_P_Q9Q  = 5'd13;
    localparam logic [4:0] S_P_P8   = 5'd14;
    localparam logic [4:0] S_H_A    = 5'd16;
    localparam logic [4:0] S_H_B    = 5'd17;
    localparam logic [4:0] S_H_C    = 5'd18;
    localparam logic [4:0] S_H_BC   = 5'd19;
    localparam logic [4:0] S_H_F    = 5'd20;
    localparam logic [4:0] S_H_X    = 5'd21;
    localparam logic [4:0] S_H_SQ   = 5'd22;
    localparam logic [4:0] S_H_OUT  = 5'd23;

    localparam logic [63:0] TEMP_MIN = -64'sd4000;
    localparam logic [63:0] TEMP_MAX = 64'd8500;
    localparam logic [63:0] HUM_MAX  = 64'd419430400;

    function automatic logic [63:0] sra(input logic [63:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx12(input logic [11:0] v);
        return {{52{v[11]}}, v};
    endfunction

    logic [2:0]  state_reg;
    logic [4:0]  step_reg;
    logic        m_valid_reg;
    out_word_t   m_data_reg;
    logic [19:0] adc_p_reg;
    logic [19:0] adc_t_reg;
    logic [15:0] adc_h_reg;
    logic [63:0] v1_reg, v2_reg, tmp_reg, tf_reg, pv_reg, hx_reg, num_reg, p_reg;
    logic [63:0] ha_reg, hb_reg, hc_reg, hf_reg, hx2_reg;
    logic [14:0] temp_reg;
    logic [31:0] press_reg;
    logic [16:0] hum_reg;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6;
    logic [63:0] d_t;
    logic [63:0] mul_a, mul_b, mul_p, div_q;
    logic        mul_start, mul_done, div_start, div_done;
    logic [63:0] t_round, p_fin, h_fin, h_a;

    assign t1 = {48'd0, cal.temp_cal[15:0]};
    assign t2 = sx16(cal.temp_cal[31:16]);
    assign t3 = sx16(cal.temp_cal[47:32]);
    assign p1 = {48'd0, cal.press_cal_lo[15:0]};
    assign p2 = sx16(cal.press_cal_lo[31:16]);
    assign p3 = sx16(cal.press_cal_lo[47:32]);
    assign p4 = sx16(cal.press_cal_lo[63:48]);
    assign p5 = sx16(cal.press_cal_hi[15:0]);
    assign p6 = sx16(cal.press_cal_hi[31:16]);
    assign p7 = sx16(cal.press_cal_hi[47:32]);
    assign p8 = sx16(cal.press_cal_hi[63:48]);
    assign p9 = sx16(cal.press_cal_nine);
    assign h1 = {56'd0, cal.hum_cal_a[7:0]};
    assign h2 = sx16(cal.hum_cal_a[23:8]);
    assign h3 = {56'd0, cal.hum_cal_a[31:24]};
    assign h4 = sx12(cal.hum_cal_b[11:0]);
    assign h5 = sx12(cal.hum_cal_b[23:12]);
    assign h6 = {{56{cal.hum_cal_b[31]}}, cal.hum_cal_b[31:24]};

    assign d_t = ({44'd0, adc_t_reg} >> 4) - t1;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            S_T_LIN: begin
                mul_a = ({44'd0, adc_t_reg} >> 3) - (t1 << 1);
                mul_b = t2;
            end
            S_T_SQ: begin
                mul_a = d_t;
                mul_b = d_t;
            end
            S_T_CUBE: begin
                mul_a = tmp_reg;
                mul_b = t3;
            end
            S_T_OUT: begin
                mul_a = tf_reg;
                mul_b = 64'd5;
            end
            S_P_SQ: begin
                mul_a = pv_reg;
                mul_b = pv_reg;
            end
            S_P_V2A: begin
                mul_a = tmp_reg;
                mul_b = p6;
            end
            S_P_V2B: begin
                mul_a = pv_reg;
                mul_b = p5;
            end
            S_P_V1A: begin
                mul_a = tmp_reg;
                mul_b = p3;
            end
            S_P_V1B: begin
                mul_a = pv_reg;
                mul_b = p2;
            end
            S_P_V1C: begin
                mul_a = 64'h0000_8000_0000_0000 + v1_reg;
                mul_b = p1;
            end
            S_P_NUM: begin
                mul_a = ((64'd1048576 - {44'd0, adc_p_reg}) << 31) - v2_reg;
                mul_b = 64'd3125;
            end
            S_P_Q9: begin
                mul_a = p9;
                mul_b = sra(p_reg, 13);
            end
            S_P_Q9Q: begin
                mul_a = tmp_reg;
                mul_b = sra(p_reg, 13);
            end
            S_P_P8: begin
                mul_a = p8;
                mul_b = p_reg;
            end
            S_H_A: begin
                mul_a = h5;
                mul_b = hx_reg;
            end
            S_H_B: begin
                mul_a = hx_reg;
                mul_b = h6;
            end
            S_H_C: begin
                mul_a = hx_reg;
                mul_b = h3;
            end
            S_H_BC: begin
                mul_a = hb_reg;
                mul_b = hc_reg;
            end
            S_H_F: begin
                mul_a = hb_reg;
                mul_b = h2;
            end
            S_H_X: begin
                mul_a = ha_reg;
                mul_b = hf_reg;
            end
            S_H_SQ: begin
                mul_a = sra(hx2_reg, 15);
                mul_b = sra(hx2_reg, 15);
            end
            S_H_OUT: begin
                mul_a = tmp_reg;
                mul_b = h1;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign t_round = sra(mul_p + 64'd128, 8);
    assign p_fin   = sra(v2_reg, 8) + (p7 << 4);
    assign h_fin   = hx2_reg - sra(mul_p, 4);
    assign h_a     = sra(({48'd0, adc_h_reg} << 14) - (h4 << 20) - mul_p + 64'd16384, 15);

    assign mul_start = (state_reg == ST_ISSUE);
    assign div_start = (state_reg == ST_DIV_ISSUE) && (v1_reg != '0);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    pth_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    pth_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (num_reg),
        .b       (v1_reg),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= S_T_LIN;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        step_reg  <= S_T_LIN;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mul_done) begin
                        step_reg <= step_reg + 1'b1;
                        case (step_reg)
                            S_P_NUM: state_reg <= ST_DIV_ISSUE;
                            S_P_P8:  state_reg <= ST_FIN;
                            S_H_OUT: state_reg <= ST_EMIT;
                            default: state_reg <= ST_ISSUE;
                        endcase
                    end
                end
                ST_DIV_ISSUE: begin
                    if (v1_reg == '0) begin
                        step_reg  <= S_H_A;
                        state_reg <= ST_ISSUE;
                    end else begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        step_reg  <= S_P_Q9;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_FIN: begin
                    step_reg  <= S_H_A;
                    state_reg <= ST_ISSUE;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            adc_p_reg <= q_data.raw_pressure;
            adc_t_reg <= q_data.raw_temperature;
            adc_h_reg <= q_data.raw_humidity;
        end
        if (state_reg == ST_DIV_ISSUE && v1_reg == '0) begin
            press_reg <= '0;
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            p_reg <= div_q;
        end
        if (state_reg == ST_FIN) begin
            if (p_fin[63]) begin
                press_reg <= '0;
            end else if (p_fin[63:32] != '0) begin
                press_reg <= '1;
            end else begin
                press_reg <= p_fin[31:0];
            end
        end
        if (state_reg == ST_EMIT && (!m_valid_reg || m_ready)) begin
            m_data_reg.temperature_centi <= temp_reg;
            m_data_reg.pressure_q24_8    <= press_reg;
            m_data_reg.humidity_q22_10   <= hum_reg;
        end
        if (state_reg == ST_WAIT && mul_done) begin
            case (step_reg)
                S_T_LIN:  v1_reg  <= sra(mul_p, 11);
                S_T_SQ:   tmp_reg <= sra(mul_p, 12);
                S_T_CUBE: tf_reg  <= v1_reg + sra(mul_p, 14);
                S_T_OUT: begin
                    if ($signed(t_round) < $signed(TEMP_MIN)) begin
                        temp_reg <= TEMP_MIN[14:0];
                    end else if ($signed(t_round) > $signed(TEMP_MAX)) begin
                        temp_reg <= TEMP_MAX[14:0];
                    end else begin
                        temp_reg <= t_round[14:0];
                    end
                    pv_reg <= tf_reg - 64'd128000;
                    hx_reg <= tf_reg - 64'd76800;
                end
                S_P_SQ:   tmp_reg <= mul_p;
                S_P_V2A:  v2_reg  <= mul_p;
                S_P_V2B:  v2_reg  <= v2_reg + (mul_p << 17);
                S_P_V1A: begin
                    v2_reg <= v2_reg + (p4 << 35);
                    v1_reg <= sra(mul_p, 8);
                end
                S_P_V1B:  v1_reg  <= v1_reg + (mul_p << 12);
                S_P_V1C:  v1_reg  <= sra(mul_p, 33);
                S_P_NUM:  num_reg <= mul_p;
                S_P_Q9:   tmp_reg <= mul_p;
                S_P_Q9Q:  v1_reg  <= sra(mul_p, 25);
                S_P_P8:   v2_reg  <= p_reg + v1_reg + sra(mul_p, 19);
                S_H_A:    ha_reg  <= h_a;
                S_H_B:    hb_reg  <= sra(mul_p, 10);
                S_H_C:    hc_reg  <= sra(mul_p, 11) + 64'd32768;
                S_H_BC:   hb_reg  <= sra(mul_p, 10) + 64'd2097152;
                S_H_F:    hf_reg  <= sra(mul_p + 64'd8192, 14);
                S_H_X:    hx2_reg <= mul_p;
                S_H_SQ:   tmp_reg <= sra(mul_p, 7);
                S_H_OUT: begin
                    if (h_fin[63]) begin
                        hum_reg <= '0;
                    end else if (h_fin > HUM_MAX) begin
                        hum_reg <= HUM_MAX[28:12];
                    end else begin
                        hum_reg <= h_fin[28:12];
                    end
                end
                default: tmp_reg <= tmp_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_mul_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == ST_WAIT)
        else $error("multiply result arrived outside wait state");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == ST_ISSUE && step_reg == S_T_LIN)
        else $error("sequencer did not start on new word");
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divide result arrived outside wait state");
`endif

endmodule

### rtl/pth_sensor_compensation_core.sv
// Pressure / temperature / humidity compensation core, top level.
// Holds the calibration registers and the APB-style port.
// Depends on pth_pkg, pth_front, pth_back.
//
// Usage:
//   Calibration is written through the APB-style port (64-bit registers at
//   byte address 8*i); write only while no measurement is in flight.
//   A raw measurement word enters on s_valid/s_ready and lands in a two-entry
//   queue; one result word per measurement leaves on m_valid/m_ready.
//   Each word is worked through a 22-step sequence on one shared 64-bit
//   multiplier plus a bit-serial divider, from queue to result register;
//   the division and the pressure steps after it are skipped when the
//   pressure divisor is zero. The sequencer takes a new word only after the
//   last one reaches the result register; two more words may wait in the queue.
//   Reset clears the queue, the sequencer and all calibration registers to 0.
//   A stalled receiver holds the result register; the sequencer finishes the
//   next word and waits, then the queue fills and s_ready drops.
module pth_sensor_compensation_core import pth_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_word_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_word_t         m_data
);
    cal_t      cal_reg;
    logic      q_valid;
    logic      q_pop;
    in_word_t  q_data;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_TEMP_CAL:       cal_reg.temp_cal       <= pwdata[47:0];
                REG_PRESS_CAL_LO:   cal_reg.press_cal_lo   <= pwdata;
                REG_PRESS_CAL_HI:   cal_reg.press_cal_hi   <= pwdata;
                REG_PRESS_CAL_NINE: cal_reg.press_cal_nine <= pwdata[15:0];
                REG_HUM_CAL_A:      cal_reg.hum_cal_a      <= pwdata[31:0];
                REG_HUM_CAL_B:      cal_reg.hum_cal_b      <= pwdata[31:0];
                default:            cal_reg                <= cal_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TEMP_CAL:       prdata = {16'd0, cal_reg.temp_cal};
            REG_PRESS_CAL_LO:   prdata = cal_reg.press_cal_lo;
            REG_PRESS_CAL_HI:   prdata = cal_reg.press_cal_hi;
            REG_PRESS_CAL_NINE: prdata = {48'd0, cal_reg.press_cal_nine};
            REG_HUM_CAL_A:      prdata = {32'd0, cal_reg.hum_cal_a};
            REG_HUM_CAL_B:      prdata = {32'd0, cal_reg.hum_cal_b};
            default:            prdata = '0;
        endcase
    end

    pth_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_data  (q_data)
    );

    pth_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cal     (cal_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### verif/tb_top.sv
// Testbench for pth_sensor_compensation_core: checks each result word against an
// integer compensation predictor, under calibration sweeps and random idling.
// Depends on pth_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import pth_pkg::*;

    localparam longint PRESS_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam longint HUM_MAX = 419430400;
    localparam int STALL_LIMIT = 20000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_word_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_word_t         m_data;

    cal_t      cal_now = '0;
    out_word_t expected_words[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles = 0;

    pth_sensor_compensation_core dut (.*);

    always #10 aclk = ~aclk;

    function automatic out_word_t compensate(in_word_t w, cal_t c);
        longint ap, at, ah, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6, v1, v2, d, tf, t, p, q, x, a, b, cc, f;
        out_word_t r;
        ap = w.raw_pressure;
        at = w.raw_temperature;
        ah = w.raw_humidity;
        t1 = c.temp_cal[15:0];
        t2 = $signed(c.temp_cal[31:16]);
        t3 = $signed(c.temp_cal[47:32]);
        p1 = c.press_cal_lo[15:0];
        p2 = $signed(c.press_cal_lo[31:16]);
        p3 = $signed(c.press_cal_lo[47:32]);
        p4 = $signed(c.press_cal_lo[63:48]);
        p5 = $signed(c.press_cal_hi[15:0]);
        p6 = $signed(c.press_cal_hi[31:16]);
        p7 = $signed(c.press_cal_hi[47:32]);
        p8 = $signed(c.press_cal_hi[63:48]);
        p9 = $signed(c.press_cal_nine);
        h1 = c.hum_cal_a[7:0];
        h2 = $signed(c.hum_cal_a[23:8]);
        h3 = c.hum_cal_a[31:24];
        h4 = $signed(c.hum_cal_b[11:0]);
        h5 = $signed(c.hum_cal_b[23:12]);
        h6 = $signed(c.hum_cal_b[31:24]);

        v1 = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = (at >>> 4) - t1;
        v2 = (((d * d) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        t = (tf * 5 + 128) >>> 8;
        if (t < -4000) t = -4000;
        else if (t > 8500) t = 8500;

        v1 = tf - 128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0) begin
            p = 0;
        end else begin
            p = 1048576 - ap;
            p = ((p <<< 31) - v2) * 3125;
            p = (v1 == -1) ? -p : p / v1;
            q = p >>> 13;
            v1 = (p9 * q * q) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            if (p < 0) p = 0;
            else if (p > PRESS_MAX) p = PRESS_MAX;
        end

        x = tf - 76800;
        a = ((ah <<< 14) - (h4 <<< 20) - h5 * x + 16384) >>> 15;
        b = (x * h6) >>> 10;
        cc = ((x * h3) >>> 11) + 32768;
        f = ((((b * cc) >>> 10) + 2097152) * h2 + 8192) >>> 14;
        x = a * f;
        x = x - (((((x >>> 15) * (x >>> 15)) >>> 7) * h1) >>> 4);
        if (x < 0) x = 0;
        else if (x > HUM_MAX) x = HUM_MAX;

        r.temperature_centi = t[14:0];
        r.pressure_q24_8 = p[31:0];
        r.humidity_q22_10 = x[28:12];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    always @(posedge aclk) begin
        out_word_t e;
        if (m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                e = expected_words.pop_front();
                if (m_data.temperature_centi !== e.temperature_centi)
                    report_mismatch($sformatf("temperature %0d, want %0d",
                        m_data.temperature_centi, e.temperature_centi));
                if (m_data.pressure_q24_8 !== e.pressure_q24_8)
                    report_mismatch($sformatf("pressure %0d, want %0d",
                        m_data.pressure_q24_8, e.pressure_q24_8));
                if (m_data.humidity_q22_10 !== e.humidity_q22_10)
                    report_mismatch($sformatf("humidity %0d, want %0d",
                        m_data.humidity_q22_10, e.humidity_q22_10));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(in_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(compensate(w, cal_now));
    endtask

    task automatic send_raw(int unsigned pr, int unsigned tr, int unsigned hr);
        in_word_t w;
        w.raw_pressure = pr[19:0];
        w.raw_temperature = tr[19:0];
        w.raw_humidity = hr[15:0];
        send_word(w);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic apb_idle();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_cal(cal_t c);
        apb_write(REG_TEMP_CAL, {16'($urandom), c.temp_cal});
        apb_write(REG_PRESS_CAL_LO, c.press_cal_lo);
        apb_write(REG_PRESS_CAL_HI, c.press_cal_hi);
        apb_write(REG_PRESS_CAL_NINE, {48'({$urandom, $urandom}), c.press_cal_nine});
        apb_write(REG_HUM_CAL_A, {$urandom, c.hum_cal_a});
        apb_write(REG_HUM_CAL_B, {$urandom, c.hum_cal_b});
        apb_idle();
        cal_now = c;
    endtask

    function automatic logic [15:0] jitter(int base, int span);
        int v;
        v = base + int'($urandom_range(2 * span)) - span;
        return v[15:0];
    endfunction

    function automatic cal_t typical_cal(int span);
        cal_t c;
        logic [11:0] h4, h5;
        h4 = 12'(313 + int'($urandom_range(2 * span)) - span);
        h5 = 12'(50 + int'($urandom_range(span)));
        c.temp_cal = {jitter(-1000, span), jitter(26435, span), jitter(27504, span)};
        c.press_cal_lo = {jitter(2855, span), jitter(3024, span),
                          jitter(-10685, span), jitter(36477, span)};
        c.press_cal_hi = {jitter(-14600, span), jitter(15500, span),
                          jitter(-7, span), jitter(140, span)};
        c.press_cal_nine = jitter(6000, span);
        c.hum_cal_a = {8'($urandom_range(span)), jitter(362, span), 8'd75};
        c.hum_cal_b = {8'd30, h5, h4};
        return c;
    endfunction

    function automatic cal_t wild_cal();
        cal_t c;
        c.temp_cal = 48'({$urandom, $urandom});
        c.press_cal_lo = {$urandom, $urandom};
        c.press_cal_hi = {$urandom, $urandom};
        c.press_cal_nine = 16'($urandom);
        c.hum_cal_a = $urandom;
        c.hum_cal_b = $urandom;
        return c;
    endfunction

    task automatic test_reset_values();
        send_raw(0, 0, 0);
        send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_raw(415148, 519888, 30000);
        drain();
    endtask

    task automatic test_typical_and_extremes();
        load_cal(typical_cal(0));
        send_raw(415148, 519888, 30000);
        send_raw(0, 0, 0);
        send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_raw(0, 20'hFFFFF, 0);
        send_raw(20'hFFFFF, 0, 16'hFFFF);
        send_raw(300000, 300000, 10000);
        send_raw(500000, 700000, 60000);
        send_raw(20'hAAAAA, 20'h55555, 16'hAAAA);
        send_raw(20'h55555, 20'hAAAAA, 16'h5555);
        drain();
    endtask

    task automatic test_zero_divisor();
        cal_t c;
        c = typical_cal(0);
        c.press_cal_lo[15:0] = '0;
        load_cal(c);
        send_raw(415148, 519888, 30000);
        send_raw(0, 0, 16'hFFFF);
        send_raw(20'hFFFFF, 20'hFFFFF, 0);
        drain();
    endtask

    task automatic test_register_extremes();
        cal_t c;
        c = '1;
        load_cal(c);
        send_raw(415148, 519888, 30000);
        send_raw(0, 0, 0);
        send_raw(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        drain();
        c = {$bits(cal_t)/2{2'b10}};
        load_cal(c);
        send_raw(415148, 519888, 30000);
        send_raw(20'hFFFFF, 0, 16'hFFFF);
        drain();
        load_cal({$bits(cal_t)/2{2'b01}});
        send_raw(415148, 519888, 30000);
        send_raw(0, 20'hFFFFF, 0);
        drain();
    endtask

    task automatic test_random(int send_pct, int recv_pct, int count);
        cal_t c;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 5; k++) begin
            case ($urandom_range(3))
                0: c = wild_cal();
                1: c = typical_cal(4000);
                default: c = typical_cal(300);
            endcase
            if ($urandom_range(9) == 0) c.press_cal_lo[15:0] = '0;
            load_cal(c);
            for (int i = 0; i < count / 5; i++) begin
                if ($urandom_range(3) == 0)
                    send_raw($urandom, $urandom, $urandom);
                else
                    send_raw($urandom_range(200000, 700000), $urandom_range(380000, 650000),
                             $urandom_range(10000, 60000));
            end
            drain();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_typical_and_extremes();
        test_zero_divisor();
        test_register_extremes();
        test_random(15, 81, 500);
        test_random(81, 15, 500);
        test_random(0, 0, 500);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
